[hw/rtl/mndh_pkg.sv]
// Package for the mask dilation block: sizes, register indexes, state and
// job types, and the side-length saturation helper. No dependencies.
`timescale 1ns / 1ps

package mndh_pkg;

  // Grid geometry: the store holds SIDE rows of SIDE bits, one row per word
  localparam int SIDE    = 64;
  localparam int AW      = $clog2(SIDE);   // row / column index width
  localparam int CW      = 7;              // coordinate and size field width
  localparam int CFG_W   = 7;              // widest configuration register
  localparam int CFG_IW  = 2;              // configuration index width
  localparam int OUT_TW  = 8;              // result tdata, padded to a byte

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_DIMS    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CELLS_X = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CELLS_Y = 2'd2;

  localparam logic [1:0] DIMS_1D    = 2'd1;
  localparam logic [1:0] DIMS_RESET = 2'd2;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // What a beat needs from the store
  typedef enum logic [1:0] {
    K_NONE,    // no store access (range error or halo corner)
    K_WRITE,   // read-modify-write of one row
    K_READ1,   // single stored bit (2D edge halo)
    K_DIL      // cross dilation over three rows
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic            status;
    logic [AW-1:0]   tr;      // target row
    logic [AW-1:0]   tc;      // target bit within the row
    logic            bit_val;
    logic            up;      // row above is in range
    logic            dn;      // row below is in range
    logic            lft;     // left neighbour is in range
    logic            rgt;     // right neighbour is in range
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_UP,
    ST_RD_DN,
    ST_DONE
  } state_t;

  // Clamp a size register to 1..SIDE
  function automatic logic [CW-1:0] sat_side(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (v == '0)
      r = CW'(1);
    else if (v > CW'(SIDE))
      r = CW'(SIDE);
    return r;
  endfunction

endpackage

[hw/rtl/mndh_decode.sv]
// Command decode: turns one input beat plus the size registers into a job
// descriptor (store access kind, row/bit targets, neighbour flags). Uses mndh_pkg.
`timescale 1ns / 1ps

module mndh_decode (
  input  logic [1:0]            dims,
  input  logic [mndh_pkg::CW-1:0] cells_x,
  input  logic [mndh_pkg::CW-1:0] cells_y,
  input  logic                  cmd,
  input  logic [mndh_pkg::CW-1:0] row,
  input  logic [mndh_pkg::CW-1:0] col,
  input  logic                  bit_req,
  output mndh_pkg::job_t        job
);
  import mndh_pkg::*;

  logic          one_d;
  logic [CW-1:0] nx;
  logic [CW-1:0] ny;
  logic [CW-1:0] colv;
  logic [CW:0]   nx_p1;
  logic [CW:0]   ny_p1;
  logic          row_oob;
  logic          col_oob;
  logic          rh;
  logic          ch;
  logic [CW-1:0] ir;
  logic [CW-1:0] ic;

  assign one_d = (dims == DIMS_1D);
  assign nx    = sat_side(cells_x);
  assign ny    = one_d ? CW'(1) : sat_side(cells_y);
  assign colv  = one_d ? '0 : col;
  assign nx_p1 = (CW+1)'(nx) + (CW+1)'(1);
  assign ny_p1 = (CW+1)'(ny) + (CW+1)'(1);

  // Extended-range checks for reads
  assign row_oob = ((CW+1)'(row) > nx_p1);
  assign col_oob = ((CW+1)'(colv) > ny_p1);
  assign rh      = (row == '0) || ((CW+1)'(row) == nx_p1);
  assign ch      = (colv == '0) || ((CW+1)'(colv) == ny_p1);

  // Interior target of a dilated read; 1D halo clamps onto the end cells
  always_comb begin
    if (one_d) begin
      if (row == '0)
        ir = '0;
      else if ((CW+1)'(row) == nx_p1)
        ir = nx - CW'(1);
      else
        ir = row - CW'(1);
      ic = '0;
    end else begin
      ir = row - CW'(1);
      ic = colv - CW'(1);
    end
  end

  always_comb begin
    job         = '0;
    job.kind    = K_NONE;
    job.bit_val = bit_req;
    if (cmd == CMD_WRITE) begin
      if (row < nx && colv < ny) begin
        job.kind = K_WRITE;
        job.tr   = row[AW-1:0];
        job.tc   = colv[AW-1:0];
      end else begin
        job.status = 1'b1;
      end
    end else if (one_d || !(rh || ch)) begin
      // dilated interior bit (1D halo copies the dilated end cell)
      if (row_oob || col_oob) begin
        job.status = 1'b1;
      end else begin
        job.kind = K_DIL;
        job.tr   = ir[AW-1:0];
        job.tc   = ic[AW-1:0];
        job.up   = (ir != '0);
        job.dn   = ((ir + CW'(1)) < nx);
        job.lft  = (ic != '0);
        job.rgt  = ((ic + CW'(1)) < ny);
      end
    end else if (row_oob || col_oob) begin
      job.status = 1'b1;
    end else if (rh && !ch) begin
      // top or bottom halo: raw bit of the adjacent edge row
      job.kind = K_READ1;
      job.tr   = (row == '0) ? '0 : AW'(nx - CW'(1));
      job.tc   = AW'(colv - CW'(1));
    end else if (ch && !rh) begin
      // left or right halo: raw bit of the adjacent edge column
      job.kind = K_READ1;
      job.tr   = AW'(row - CW'(1));
      job.tc   = (colv == '0) ? '0 : AW'(ny - CW'(1));
    end
    // halo corners keep K_NONE with status 0 and read as zero
  end

endmodule

[hw/rtl/mask_neighbour_dilation_with_halo_core.sv]
// Top level of the mask dilation block: row-wide mask memory, sequencer,
// configuration registers and result register. Uses mndh_pkg and mndh_decode.
//
//   port group   dir   beat contents
//   in_*         in    cmd, row, col, bit_req (16 bits)
//   out_*        out   extended_bit, status (2 bits, padded to 8)
//   cfg_*        in    register index, write data (no handshake)
//
// Dilated read: states ST_RD_CUR, ST_RD_UP, ST_RD_DN, ST_DONE (reads of the current,
// upper and lower row through the single memory read port). Edge-halo read and
// write: ST_RD_CUR, ST_RD_UP, ST_DONE (one row read; a write puts the modified row
// back). Range errors and halo corners go straight to ST_DONE. A new beat is taken in
// the cycle the previous result enters the output register. rst_n is synchronous;
// the memory is not cleared. A stalled result holds the sequencer in its last state.
`timescale 1ns / 1ps

module mask_neighbour_dilation_with_halo_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // cfg
  input  logic                          cfg_we,
  input  logic [mndh_pkg::CFG_IW-1:0]   cfg_idx,
  input  logic [mndh_pkg::CFG_W-1:0]    cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // cmd[0], row[7:1], col[14:8], bit_req[15]
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mndh_pkg::OUT_TW-1:0]   out_tdata   // extended_bit[0], status[1], zero[7:2]
);
  import mndh_pkg::*;

  // Configuration registers
  logic [1:0]    dims_r;
  logic [CW-1:0] cells_x_r;
  logic [CW-1:0] cells_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r    <= DIMS_RESET;
      cells_x_r <= CW'(SIDE);
      cells_y_r <= CW'(SIDE);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DIMS:    dims_r    <= cfg_wdata[1:0];
        REG_CELLS_X: cells_x_r <= cfg_wdata[CW-1:0];
        REG_CELLS_Y: cells_y_r <= cfg_wdata[CW-1:0];
        default:     ;
      endcase
    end
  end

  // Beat decode
  job_t dec_job;

  mndh_decode u_decode (
    .dims    (dims_r),
    .cells_x (cells_x_r),
    .cells_y (cells_y_r),
    .cmd     (in_tdata[0]),
    .row     (in_tdata[7:1]),
    .col     (in_tdata[14:8]),
    .bit_req (in_tdata[15]),
    .job     (dec_job)
  );

  // Sequencer registers
  state_t             state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic               res_r, res_nxt;
  logic               out_tvalid_r, out_valid_nxt;
  logic [OUT_TW-1:0]  out_tdata_r, out_data_nxt;
  logic               in_ready;
  logic               out_free;
  logic               fin_bit;
  logic               cur_dil;

  // Mask memory: one row of SIDE bits per word, registered read
  logic [SIDE-1:0] mem [SIDE];
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [SIDE-1:0] rd_r;
  logic            wr_en;
  logic [SIDE-1:0] wr_row;

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[job_r.tr] <= wr_row;
    if (rd_en)
      rd_r <= mem[rd_addr];
  end

  assign out_free = !out_tvalid_r || out_tready;

  // Row with the written bit replaced
  always_comb begin
    wr_row              = rd_r;
    wr_row[job_r.tc]    = job_r.bit_val;
  end

  // Cross dilation within the current row
  assign cur_dil = rd_r[job_r.tc]
                 | (job_r.lft & rd_r[AW'(job_r.tc - AW'(1))])
                 | (job_r.rgt & rd_r[AW'(job_r.tc + AW'(1))]);

  // Final bit: for dilation, the lower row arrives in the last cycle
  assign fin_bit = res_r | ((job_r.kind == K_DIL) & job_r.dn & rd_r[job_r.tc]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_data_nxt;
  end

  // Next state, memory control and result register load
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    rd_addr       = job_r.tr;
    wr_en         = 1'b0;
    out_valid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt  = out_tdata_r;
    in_ready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RD_CUR: begin
        rd_en     = 1'b1;
        rd_addr   = job_r.tr;
        state_nxt = ST_RD_UP;
      end
      ST_RD_UP: begin
        state_nxt = ST_DONE;
        case (job_r.kind)
          K_WRITE: begin
            wr_en   = 1'b1;
            res_nxt = 1'b0;
          end
          K_READ1: res_nxt = rd_r[job_r.tc];
          K_DIL: begin
            res_nxt   = cur_dil;
            rd_en     = 1'b1;
            rd_addr   = job_r.tr - AW'(1);
            state_nxt = ST_RD_DN;
          end
          default: res_nxt = 1'b0;
        endcase
      end
      ST_RD_DN: begin
        res_nxt   = res_r | (job_r.up & rd_r[job_r.tc]);
        rd_en     = 1'b1;
        rd_addr   = job_r.tr + AW'(1);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_TW-2)'(0), job_r.status, fin_bit};
          in_ready      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // New beat
    if (in_tvalid && in_ready) begin
      job_nxt   = dec_job;
      res_nxt   = 1'b0;
      state_nxt = (dec_job.kind == K_NONE) ? ST_DONE : ST_RD_CUR;
    end
  end

  assign in_tready  = in_ready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // An error result never carries a set mask bit
  a_err_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[1] && out_tdata[0]))
    else $error("error result with extended bit set");

  // An accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("accepted beat left sequencer idle");

  // Write-back never shares a cycle with a row read
  a_wb_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en)
    else $error("row write-back overlaps a read");

  // A new result only appears after the sequencer finished a beat
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result loaded outside the done state");

endmodule
